>>> hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue unit.
package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int POS_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 7;
    localparam int CMDQ_DEPTH    = 2;

    // opcodes on s_op
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // status codes on m_status
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_PUSH_BACK,
        KIND_PUSH_FRONT,
        KIND_POP_BACK,
        KIND_POP_FRONT,
        KIND_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } cmd_t;

endpackage

>>> hdl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: front end, command queue, back end.
//
// Bounded deque of signed 32-bit words held in a DEPTH-entry ring buffer.
// Each input word carries one op (push back, push front, pop back, pop
// front, read at position); each produces exactly one result word with a
// status code, the read data (zero unless a successful read), the front
// entry after the op (zero when empty) and the occupancy after the op.
// A push into a full queue is dropped with status FULL, a pop from an empty
// queue reports EMPTY, and a read at or beyond the occupancy reports RANGE;
// undefined opcodes change nothing and report OK. The back-end sequencer
// takes a new command only once the previous result is loaded: state EXEC
// updates the pointers and writes the entry RAM, state READ does the
// registered RAM read of the requested slot and the front slot, and state
// DONE loads the output register, waiting while the last result is untaken.
// A 2-deep command queue between front and back absorbs up to two more
// words while a result waits on m_ready; s_ready drops once that queue is
// full. No clearing pass after reset: entries are only ever returned after
// being written. occupancy reports the count modulo 128.
module double_ended_queue_unit #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [dq_pkg::OP_W-1:0]      s_op,
    input  logic signed [dq_pkg::DATA_W-1:0]    s_value,
    input  logic        [dq_pkg::POS_W-1:0]     s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [dq_pkg::STATUS_W-1:0]  m_status,
    output logic signed [dq_pkg::DATA_W-1:0]    m_read_value,
    output logic signed [dq_pkg::DATA_W-1:0]    m_front_value,
    output logic        [dq_pkg::OCC_W-1:0]     m_occupancy
);

    logic         cmd_valid;
    logic         cmd_ready;
    dq_pkg::cmd_t cmd;

    // decode + command queue
    dq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_value    (s_value),
        .s_position (s_position),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // storage, pointer logic, result register
    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_front_value (m_front_value),
        .m_occupancy   (m_occupancy)
    );

    // read data is only returned on a successful read
    a_read_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != dq_pkg::STATUS_OK)) |-> (m_read_value == '0))
        else $error("read data nonzero on failed op");

    // occupancy never exceeds the buffer depth (when it fits the port)
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((DEPTH > 127) || (int'(m_occupancy) <= DEPTH)))
        else $error("occupancy above depth");

    // an empty queue shows a zero front word
    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_occupancy == '0)) |-> ((DEPTH > 127) || (m_front_value == '0)))
        else $error("front word nonzero while empty");

    // a full-push drop implies the queue reports full
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == dq_pkg::STATUS_FULL))
            |-> ((DEPTH > 127) || (int'(m_occupancy) == DEPTH)))
        else $error("push dropped while not full");

endmodule

>>> hdl/dq_front.sv
// Front end: accepts input words, decodes the opcode and queues commands.
module dq_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic        [dq_pkg::OP_W-1:0]    s_op,
    input  logic signed [dq_pkg::DATA_W-1:0]  s_value,
    input  logic        [dq_pkg::POS_W-1:0]   s_position,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output dq_pkg::cmd_t                      cmd
);

    localparam int QW = $clog2(dq_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(dq_pkg::CMDQ_DEPTH + 1);

    dq_pkg::cmd_t   q_mem [dq_pkg::CMDQ_DEPTH];
    logic [QW-1:0]  wptr_reg, wptr_next;
    logic [QW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  cnt_reg,  cnt_next;
    dq_pkg::cmd_t   dec_cmd;
    logic           push, pop;

    // opcode decode
    always_comb begin
        dec_cmd.value    = s_value;
        dec_cmd.position = s_position;
        unique case (s_op)
            dq_pkg::OP_PUSH_BACK:  dec_cmd.kind = dq_pkg::KIND_PUSH_BACK;
            dq_pkg::OP_PUSH_FRONT: dec_cmd.kind = dq_pkg::KIND_PUSH_FRONT;
            dq_pkg::OP_POP_BACK:   dec_cmd.kind = dq_pkg::KIND_POP_BACK;
            dq_pkg::OP_POP_FRONT:  dec_cmd.kind = dq_pkg::KIND_POP_FRONT;
            dq_pkg::OP_READ:       dec_cmd.kind = dq_pkg::KIND_READ;
            default:               dec_cmd.kind = dq_pkg::KIND_NOP;
        endcase
    end

    assign s_ready   = (cnt_reg != CW'(dq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == QW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == QW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= dec_cmd;
        end
    end

endmodule

>>> hdl/dq_back.sv
// Back end: ring buffer storage, pointer/count update and result register.
module dq_back #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  dq_pkg::cmd_t                        cmd,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [dq_pkg::STATUS_W-1:0]  m_status,
    output logic signed [dq_pkg::DATA_W-1:0]    m_read_value,
    output logic signed [dq_pkg::DATA_W-1:0]    m_front_value,
    output logic        [dq_pkg::OCC_W-1:0]     m_occupancy
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > dq_pkg::POS_W) ? CNT_W : dq_pkg::POS_W;
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    typedef enum logic [2:0] {
        ST_EXEC = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

    back_state_t                 state_reg, state_next;
    logic [PTR_W-1:0]            fp_reg, fp_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [dq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [PTR_W-1:0]            raddr_reg, raddr_next;
    logic [dq_pkg::DATA_W-1:0]   rd_a_reg, rd_b_reg;
    logic                        m_valid_reg;
    logic [dq_pkg::STATUS_W-1:0] m_status_reg;
    logic [dq_pkg::DATA_W-1:0]   m_read_value_reg, m_front_value_reg;
    logic [dq_pkg::OCC_W-1:0]    m_occupancy_reg;

    logic                        mem_we;
    logic [PTR_W-1:0]            mem_waddr;
    logic [PTR_W-1:0]            fp_dec, fp_inc;
    logic                        is_full, is_empty, load_out;

    // (base + off) mod DEPTH, both operands below DEPTH
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty  = (cnt_reg == '0);
    assign fp_dec    = (fp_reg == '0) ? PTR_W'(DEPTH - 1) : fp_reg - 1'b1;
    assign fp_inc    = (fp_reg == PTR_W'(DEPTH - 1)) ? '0 : fp_reg + 1'b1;
    assign cmd_ready = (state_reg == ST_EXEC);

    always_comb begin
        state_next  = state_reg;
        fp_next     = fp_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        raddr_next  = raddr_reg;
        mem_we      = 1'b0;
        mem_waddr   = slot_of(fp_reg, PTR_W'(cnt_reg));
        load_out    = 1'b0;
        unique case (state_reg)
            ST_EXEC: begin
                if (cmd_valid) begin
                    status_next = dq_pkg::STATUS_OK;
                    rd_ok_next  = 1'b0;
                    raddr_next  = slot_of(fp_reg, PTR_W'(cmd.position));
                    state_next  = ST_READ;
                    unique case (cmd.kind)
                        dq_pkg::KIND_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = dq_pkg::STATUS_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        dq_pkg::KIND_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = dq_pkg::STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = fp_dec;
                                fp_next   = fp_dec;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        dq_pkg::KIND_POP_BACK: begin
                            if (is_empty) begin
                                status_next = dq_pkg::STATUS_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        dq_pkg::KIND_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = dq_pkg::STATUS_EMPTY;
                            end else begin
                                fp_next  = fp_inc;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        dq_pkg::KIND_READ: begin
                            if (CMP_W'(cmd.position) >= CMP_W'(cnt_reg)) begin
                                status_next = dq_pkg::STATUS_RANGE;
                            end else begin
                                rd_ok_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            default: state_next = ST_EXEC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_EXEC;
            fp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fp_reg    <= fp_next;
            cnt_reg   <= cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
        raddr_reg  <= raddr_next;
        if (load_out) begin
            m_status_reg      <= status_reg;
            m_read_value_reg  <= rd_ok_reg ? rd_a_reg : '0;
            m_front_value_reg <= is_empty ? '0 : rd_b_reg;
            m_occupancy_reg   <= dq_pkg::OCC_W'(cnt_reg);
        end
    end

    // entry storage: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= cmd.value;
        end
        if (state_reg == ST_READ) begin
            rd_a_reg <= mem[raddr_reg];
            rd_b_reg <= mem[fp_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_front_value = m_front_value_reg;
    assign m_occupancy   = m_occupancy_reg;

endmodule
